### rtl/amo_pkg.sv
// ----------------------------------------------------------------------------
// amo_pkg
// Shared types and constants of the atomic memory operation unit: the
// request and response beats, the operation codes and the write port bundle.
// ----------------------------------------------------------------------------
package amo_pkg;

  // Number of atomic words held in the store
  localparam int NUM_WORDS = 256;
  // Width of an index into the store
  localparam int IDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int WORD_W    = 32;

  // Operation codes; codes above AMO_ADD_BGE_SET behave as a load
  typedef enum logic [3:0] {
    AMO_LOAD        = 4'd0,
    AMO_EXCHANGE    = 4'd1,
    AMO_ADD         = 4'd2,
    AMO_SUB         = 4'd3,
    AMO_XOR         = 4'd4,
    AMO_AND         = 4'd5,
    AMO_OR          = 4'd6,
    AMO_STORE       = 4'd7,
    AMO_TAS         = 4'd8,
    AMO_CLEAR       = 4'd9,
    AMO_CAS         = 4'd10,
    AMO_BGE_SET     = 4'd11,
    AMO_ADD_BGE_SET = 4'd12
  } amo_op_e;

  // Request beat
  typedef struct packed {
    logic        [3:0]        req_type;
    logic        [7:0]        word_addr;
    logic signed [WORD_W-1:0] operand;
    logic signed [WORD_W-1:0] expected_value;
    logic signed [WORD_W-1:0] limit;
    logic signed [WORD_W-1:0] addend;
  } amo_req_t;

  // Response beat
  typedef struct packed {
    logic signed [WORD_W-1:0] ret_value;
    logic signed [WORD_W-1:0] prior_value;
  } amo_rsp_t;

  // Write-back port into the word store
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] data;
  } amo_wr_t;

endpackage

### rtl/amo_store.sv
// ----------------------------------------------------------------------------
// amo_store
// Word store: a synchronous single-read, single-write memory with registered
// read data, per-word valid bits that stand for the all-zero reset
// contents, and a bypass of a write that lands in the same cycle as a read
// of the same word.
// ----------------------------------------------------------------------------
module amo_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [amo_pkg::IDX_W-1:0] rd_idx_i,
  input  amo_pkg::amo_wr_t          wr_i,
  output logic [amo_pkg::WORD_W-1:0] rd_word_o
);
  import amo_pkg::*;

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_q;

  logic [WORD_W-1:0] rd_data_q;
  logic              rd_vld_q;
  logic              fwd_q;
  logic [WORD_W-1:0] fwd_data_q;

  // Memory array: read-before-write, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  // Valid bits: a word never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  // Read-side flags and bypass of a colliding write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else if (rd_en_i) begin
      rd_vld_q <= vld_q[rd_idx_i];
      fwd_q    <= wr_i.en && (wr_i.idx == rd_idx_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_i.data;
    end
  end

  // Word as seen by the request in flight
  always_comb begin
    if (fwd_q) begin
      rd_word_o = fwd_data_q;
    end else if (rd_vld_q) begin
      rd_word_o = rd_data_q;
    end else begin
      rd_word_o = '0;
    end
  end

endmodule

### rtl/amo_alu.sv
// ----------------------------------------------------------------------------
// amo_alu
// Modify step of the read-modify-write: computes the new word and the
// returned value from the prior word and the request.
// ----------------------------------------------------------------------------
module amo_alu (
  input  amo_pkg::amo_req_t          req_i,
  input  logic [amo_pkg::WORD_W-1:0] prior_i,
  output logic [amo_pkg::WORD_W-1:0] next_o,
  output logic [amo_pkg::WORD_W-1:0] ret_o
);
  import amo_pkg::*;

  logic [WORD_W-1:0] opnd;
  logic [WORD_W-1:0] sum;
  logic              sum_ge;
  logic              prior_ge;

  assign opnd     = req_i.operand;
  assign sum      = prior_i + req_i.addend;
  assign sum_ge   = $signed(sum) >= $signed(req_i.limit);
  assign prior_ge = $signed(prior_i) >= $signed(req_i.limit);

  // New word and return value per operation
  always_comb begin
    next_o = prior_i;
    ret_o  = prior_i;
    case (amo_op_e'(req_i.req_type))
      AMO_EXCHANGE: next_o = opnd;
      AMO_ADD:      next_o = prior_i + opnd;
      AMO_SUB:      next_o = prior_i - opnd;
      AMO_XOR:      next_o = prior_i ^ opnd;
      AMO_AND:      next_o = prior_i & opnd;
      AMO_OR:       next_o = prior_i | opnd;
      AMO_STORE:    next_o = opnd;
      AMO_TAS: begin
        if (prior_i == '0) begin
          next_o = WORD_W'(1);
        end
      end
      AMO_CLEAR:    next_o = '0;
      AMO_CAS: begin
        if (prior_i == req_i.expected_value) begin
          next_o = opnd;
          ret_o  = WORD_W'(1);
        end else begin
          ret_o  = '0;
        end
      end
      AMO_BGE_SET: begin
        if (prior_ge) begin
          next_o = opnd;
          ret_o  = '0;
        end else begin
          ret_o  = WORD_W'(1);
        end
      end
      AMO_ADD_BGE_SET: next_o = sum_ge ? opnd : sum;
      default: ;
    endcase
  end

endmodule

### rtl/atomic_memory_op_unit.sv
// ----------------------------------------------------------------------------
// atomic_memory_op_unit
// Indivisible read-modify-write operations on a store of 32-bit words.
// ----------------------------------------------------------------------------
// The unit takes one request beat per cycle while in_stall_o is low and
// answers each with exactly one response beat, in order. A request reads
// its word from the store at the edge where it is accepted, is modified
// and written back as it leaves the request stage, and its response is
// then held in the output register. The single read port and single write
// port of the store set that rate; a request that follows one to the same
// word picks up the new contents through a bypass, so back-to-back hits
// cost nothing. Reset clears the store at once through per-word valid bits,
// so the unit is ready right after reset with no clearing pass. An address
// beyond the store reads zero and writes nothing.
// ----------------------------------------------------------------------------
module atomic_memory_op_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  amo_pkg::amo_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output amo_pkg::amo_rsp_t out_rsp_o
);
  import amo_pkg::*;

  logic     accept;
  logic     out_free;
  logic     s1_fire;
  logic     s1_valid_q, s1_valid_d;
  amo_req_t s1_req_q;
  logic     s1_inside_q;
  logic     in_inside;

  logic [WORD_W-1:0] store_word;
  logic [WORD_W-1:0] prior;
  logic [WORD_W-1:0] next_word;
  logic [WORD_W-1:0] ret_word;
  amo_wr_t           wr;

  logic     out_valid_q, out_valid_d;
  amo_rsp_t out_rsp_q;

  // Handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_inside  = 32'(in_req_i.word_addr) < 32'(NUM_WORDS);

  // Stage holding the request while its word is read
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q    <= in_req_i;
      s1_inside_q <= in_inside;
    end
  end

  // Word store
  amo_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_idx_i  (IDX_W'(in_req_i.word_addr)),
    .wr_i      (wr),
    .rd_word_o (store_word)
  );

  assign prior = s1_inside_q ? store_word : '0;

  // Modify
  amo_alu u_alu (
    .req_i   (s1_req_q),
    .prior_i (prior),
    .next_o  (next_word),
    .ret_o   (ret_word)
  );

  // Write back
  always_comb begin
    wr.en   = s1_fire && s1_inside_q;
    wr.idx  = IDX_W'(s1_req_q.word_addr);
    wr.data = next_word;
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_rsp_q.ret_value   <= ret_word;
      out_rsp_q.prior_value <= prior;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // A request in flight always yields a response beat next cycle
  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_o)
    else $error("request in flight produced no response beat");

  // Input is held off only while a request waits for the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a waiting request");

  // A waiting request keeps its contents
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_req_q)))
    else $error("waiting request lost or changed");

  // The store is written only by a request inside it
  a_write_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (s1_fire && s1_inside_q))
    else $error("write outside a firing in-range request");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the atomic memory operation unit.
// ----------------------------------------------------------------------------
// Runs a short directed set that covers every operation, the signed and
// wrapping extremes and the unused request codes. It then sends a long
// random stream that mostly hits a few hot words, so that back-to-back
// requests to one word are common. A shadow copy of the word store predicts
// each response. Responses are checked in order against that prediction.
// Both sides idle in random bursts, and the tail of the run is sent at full
// rate.
// ----------------------------------------------------------------------------
module testbench;
  import amo_pkg::*;

  localparam int NUM_RANDOM = 1830;
  localparam int TAIL_ITEMS = 150;
  localparam int SETTLE_CYC = 8;
  // The limit allows several times the worst case with full gaps and stalls.
  localparam int LIMIT_CYC  = 400000;

  // Shadow store, response predictor and in-order response check
  class amo_tracker;
    logic signed [WORD_W-1:0] words [NUM_WORDS];
    amo_rsp_t                 awaited_rsp_q [$];
    int unsigned              errors;

    function new();
      foreach (words[i]) words[i] = '0;
      errors = 0;
    endfunction

    function logic signed [WORD_W-1:0] word_at(logic [7:0] addr);
      return (addr < NUM_WORDS) ? words[addr] : '0;
    endfunction

    function int unsigned outstanding();
      return awaited_rsp_q.size();
    endfunction

    function void report(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h, actual %h", what, want, got);
    endfunction

    // Apply one accepted request to the shadow store and queue its response
    function void record_request(amo_req_t r);
      logic signed [WORD_W-1:0] prior;
      logic signed [WORD_W-1:0] nxt;
      logic signed [WORD_W-1:0] ret;
      logic signed [WORD_W-1:0] sum;
      amo_rsp_t                 rsp;
      bit                       hit;
      hit   = r.word_addr < NUM_WORDS;
      prior = hit ? words[r.word_addr] : '0;
      nxt   = prior;
      ret   = prior;
      sum   = prior + r.addend;
      case (r.req_type)
        AMO_EXCHANGE, AMO_STORE: nxt = r.operand;
        AMO_ADD:   nxt = prior + r.operand;
        AMO_SUB:   nxt = prior - r.operand;
        AMO_XOR:   nxt = prior ^ r.operand;
        AMO_AND:   nxt = prior & r.operand;
        AMO_OR:    nxt = prior | r.operand;
        AMO_TAS:   if (prior == 0) nxt = 1;
        AMO_CLEAR: nxt = '0;
        AMO_CAS: begin
          if (prior == r.expected_value) begin
            nxt = r.operand;
            ret = 1;
          end else begin
            ret = 0;
          end
        end
        AMO_BGE_SET: begin
          if ($signed(prior) >= $signed(r.limit)) begin
            nxt = r.operand;
            ret = 0;
          end else begin
            ret = 1;
          end
        end
        AMO_ADD_BGE_SET: nxt = ($signed(sum) >= $signed(r.limit)) ? r.operand : sum;
        default: ;  // unused codes act as a load
      endcase
      if (hit) words[r.word_addr] = nxt;
      rsp.ret_value   = ret;
      rsp.prior_value = prior;
      awaited_rsp_q.push_back(rsp);
    endfunction

    function void check_response(amo_rsp_t got);
      amo_rsp_t want;
      if (awaited_rsp_q.size() == 0) begin
        report("unexpected response", '0, got.ret_value);
        return;
      end
      want = awaited_rsp_q.pop_front();
      if (got.ret_value !== want.ret_value)
        report("ret_value", want.ret_value, got.ret_value);
      if (got.prior_value !== want.prior_value)
        report("prior_value", want.prior_value, got.prior_value);
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  amo_req_t in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  amo_rsp_t out_rsp_o;

  amo_tracker  tracker = new();
  bit          quiet_tail = 1'b0;
  int unsigned stall_left = 0;
  int unsigned stall_rate = 0;
  int unsigned cyc_count  = 0;

  atomic_memory_op_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Receiver: stall bursts at a rate that is redrawn periodically
  always @(posedge clk_i) begin
    cyc_count++;
    if (cyc_count % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_rate = 0;
        1: stall_rate = 3;
        2: stall_rate = 8;
        default: stall_rate = 20;
      endcase
    end
    if (quiet_tail) begin
      out_stall_i <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1)
        stall_left = $urandom_range(1, 14);
    end
  end

  // Response monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_response(out_rsp_o);
  end

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3: return -1;
      4: return $signed($urandom_range(0, 31)) - 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic amo_req_t make_req(amo_op_e op, logic [7:0] addr,
                                        logic [31:0] opnd, logic [31:0] expv,
                                        logic [31:0] lim, logic [31:0] addv);
    amo_req_t r;
    r.req_type       = op;
    r.word_addr      = addr;
    r.operand        = opnd;
    r.expected_value = expv;
    r.limit          = lim;
    r.addend         = addv;
    return r;
  endfunction

  // Random request, biased towards hot words and towards the edges of
  // the compare operations
  function automatic amo_req_t random_request(logic [7:0] prev_addr);
    amo_req_t                 r;
    logic signed [WORD_W-1:0] cur;
    int unsigned              pick;
    pick = $urandom_range(0, 9);
    if (pick < 5)      r.word_addr = prev_addr;
    else if (pick < 8) r.word_addr = 8'($urandom_range(0, 7));
    else               r.word_addr = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 15) == 0) r.req_type = 4'($urandom_range(13, 15));
    else                            r.req_type = 4'($urandom_range(0, 12));
    r.operand        = rand_word();
    r.expected_value = rand_word();
    r.limit          = rand_word();
    r.addend         = rand_word();
    cur = tracker.word_at(r.word_addr);
    if ($urandom_range(0, 1) == 1) begin
      case (r.req_type)
        AMO_CAS:         r.expected_value = cur;
        AMO_BGE_SET:     r.limit = cur + $signed($urandom_range(0, 2)) - 1;
        AMO_ADD_BGE_SET: r.limit = cur + r.addend + $signed($urandom_range(0, 2)) - 1;
        default: ;
      endcase
    end
    return r;
  endfunction

  // One request beat; returns at the edge where it is taken
  task automatic send_beat(input amo_req_t req);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    tracker.record_request(req);
  endtask

  task automatic idle_gap(input int unsigned n);
    in_valid_i <= 1'b0;
    in_req_i   <= $bits(amo_req_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every awaited response has arrived
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
  endtask

  // Stimulus
  initial begin
    logic [7:0]  last_addr;
    int unsigned gap_rate;
    last_addr = '0;
    gap_rate  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, wrap-around, signed edges, unused codes
    send_beat(make_req(AMO_LOAD,     8'd0,   0, 0, 0, 0));
    send_beat(make_req(AMO_STORE,    8'd255, 32'h7FFF_FFFF, 0, 0, 0));
    send_beat(make_req(AMO_ADD,      8'd255, 1, 0, 0, 0));
    send_beat(make_req(AMO_SUB,      8'd255, 1, 0, 0, 0));
    send_beat(make_req(AMO_EXCHANGE, 8'd0,   32'h8000_0000, 0, 0, 0));
    send_beat(make_req(AMO_XOR,      8'd0,   32'hFFFF_FFFF, 0, 0, 0));
    send_beat(make_req(AMO_AND,      8'd0,   32'h0F0F_0F0F, 0, 0, 0));
    send_beat(make_req(AMO_OR,       8'd0,   32'hF0F0_F0F0, 0, 0, 0));
    send_beat(make_req(AMO_TAS,      8'd1,   0, 0, 0, 0));
    send_beat(make_req(AMO_TAS,      8'd1,   0, 0, 0, 0));
    send_beat(make_req(AMO_CLEAR,    8'd1,   0, 0, 0, 0));
    send_beat(make_req(AMO_CAS,      8'd2,   5, 0, 0, 0));
    send_beat(make_req(AMO_CAS,      8'd2,   9, 0, 0, 0));
    send_beat(make_req(AMO_BGE_SET,  8'd3,   7, 0, 32'h8000_0000, 0));
    send_beat(make_req(AMO_BGE_SET,  8'd3,   3, 0, 32'h7FFF_FFFF, 0));
    send_beat(make_req(AMO_BGE_SET,  8'd3,   2, 0, 7, 0));
    send_beat(make_req(AMO_ADD_BGE_SET, 8'd4, 32'hFFFF_FFFF, 0,
                       32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_beat(make_req(AMO_ADD_BGE_SET, 8'd4, 11, 0, 0, 32'h8000_0000));
    send_beat(make_req(AMO_ADD_BGE_SET, 8'd4, 12, 0, 100, 1));
    send_beat(make_req(amo_op_e'(4'd13), 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_beat(make_req(amo_op_e'(4'd14), 8'd255, 0, 0, 0, 0));
    send_beat(make_req(amo_op_e'(4'd15), 8'd255, 1, 1, 1, 1));
    drain();

    // random stream
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_rate = 0;
          1: gap_rate = 4;
          default: gap_rate = 16;
        endcase
      end
      if (i == NUM_RANDOM - TAIL_ITEMS) quiet_tail = 1'b1;
      if (i == NUM_RANDOM / 2)
        drain();
      else if (!quiet_tail && gap_rate != 0 && $urandom_range(1, gap_rate) == 1)
        idle_gap($urandom_range(1, 14));
      begin
        amo_req_t req;
        req = random_request(last_addr);
        last_addr = req.word_addr;
        send_beat(req);
      end
    end

    // wind down
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.outstanding() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * LIMIT_CYC);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
